/* rtl/core/spoc_pkg.sv */
// Shared types, constants and byte-compare functions of the pattern occurrence counter.
package spoc_pkg;

    localparam int BYTE_W          = 8;
    localparam int PATTERN_W       = 64;
    localparam int LEN_W           = 4;
    localparam int COUNT_W         = 32;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_INDEX_W     = 2;
    localparam int MAX_PATTERN_DEF = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PATTERN_BYTES  = 2'd0,
        CFG_PATTERN_LENGTH = 2'd1,
        CFG_IGNORE_CASE    = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              stream_start;
    } t_text_item;

    typedef struct packed {
        logic               match_hit;
        logic [COUNT_W-1:0] match_count;
    } t_result_item;

    // Control shared by every window cell.
    typedef struct packed {
        logic shift;        // a text byte transfers this cycle
        logic clear;        // that byte opens a new stream
        logic ignore_case;
    } t_cell_ctrl;

    // Control from the compare row into the counter stage.
    typedef struct packed {
        logic take;
        logic restart;
        logic hit;
    } t_count_ctrl;

    function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b,
                                                    input logic ignore_case);
        logic [BYTE_W-1:0] f;
        f = b;
        if (ignore_case && b >= 8'h41 && b <= 8'h5A) begin
            f = b | 8'h20;
        end
        return f;
    endfunction

    function automatic logic byte_match(input logic [BYTE_W-1:0] a,
                                        input logic [BYTE_W-1:0] b,
                                        input logic ignore_case);
        return fold_byte(a, ignore_case) == fold_byte(b, ignore_case);
    endfunction

endpackage

/* rtl/core/spoc_text_if.sv */
// Valid/ready channel carrying text bytes into the counter.
interface spoc_text_if;
    logic                   valid;
    logic                   ready;
    spoc_pkg::t_text_item   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/spoc_result_if.sv */
// Valid/ready channel carrying hit flag and running count out of the counter.
interface spoc_result_if;
    logic                   valid;
    logic                   ready;
    spoc_pkg::t_result_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/spoc_cell.sv */
// One window cell: holds an earlier text byte and compares it with its aligned pattern byte.
module spoc_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  spoc_pkg::t_cell_ctrl            i_ctrl,
    input  logic [spoc_pkg::BYTE_W-1:0]     i_byte,
    input  logic                            i_valid,
    input  logic [spoc_pkg::BYTE_W-1:0]     i_pattern_byte,
    input  logic                            i_tap_en,
    output logic [spoc_pkg::BYTE_W-1:0]     o_byte,
    output logic                            o_valid,
    output logic                            o_tap_ok
);

    logic [spoc_pkg::BYTE_W-1:0] r_byte;
    logic [spoc_pkg::BYTE_W-1:0] n_byte;
    logic                        r_valid;
    logic                        n_valid;

    always_comb begin
        n_byte  = i_ctrl.shift ? i_byte  : r_byte;
        n_valid = i_ctrl.shift ? i_valid : r_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    // A held byte from before a stream start counts as absent.
    assign o_tap_ok = !i_tap_en
                    || (r_valid && !i_ctrl.clear
                        && spoc_pkg::byte_match(r_byte, i_pattern_byte, i_ctrl.ignore_case));
    assign o_byte   = r_byte;
    assign o_valid  = r_valid;

endmodule

/* rtl/core/spoc_count.sv */
// Saturating occurrence counter and output register of the result channel.
module spoc_count (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  spoc_pkg::t_count_ctrl           i_ctrl,
    input  logic                            i_out_ready,
    output logic                            o_in_ready,
    output logic                            o_out_valid,
    output logic                            o_hit,
    output logic [spoc_pkg::COUNT_W-1:0]    o_count
);

    logic [spoc_pkg::COUNT_W-1:0] r_total;
    logic [spoc_pkg::COUNT_W-1:0] n_total;
    logic [spoc_pkg::COUNT_W-1:0] base;
    logic                         r_out_valid;
    logic                         n_out_valid;
    logic                         r_hit;
    logic [spoc_pkg::COUNT_W-1:0] r_count;

    always_comb begin
        base    = i_ctrl.restart ? '0 : r_total;
        n_total = (i_ctrl.hit && base != '1) ? base + spoc_pkg::COUNT_W'(1) : base;
        if (i_ctrl.take) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctrl.take) begin
                r_total <= n_total;
            end
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.take) begin
            r_hit   <= i_ctrl.hit;
            r_count <= n_total;
        end
    end

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_hit       = r_hit;
    assign o_count     = r_count;

endmodule

/* rtl/core/stream_pattern_occurrence_counter.sv */
// Top level of the streaming fixed-pattern occurrence counter.
//
// Counts every position in a byte stream where a configured pattern of 1 to
// MAX_PATTERN bytes ends, overlaps and one-byte patterns included, optionally
// folding ASCII A-Z to a-z on both text and pattern. One text byte transfers
// per clock and gives exactly one result, a hit flag and the running count
// (saturating at all ones), in the cycle after the input transfer. The rate is
// one byte per cycle: the current byte and a row of MAX_PATTERN-1 window cells
// are compared with the pattern in the same cycle, and a single output
// register parts the two channels, so the input stays ready whenever that
// register is empty or is being drained. A byte with stream_start set clears
// the window and the count before it is counted. Configuration (pattern bytes,
// length, ignore-case) is written through i_cfg_we/i_cfg_index/i_cfg_data;
// the user must do so only while the stream is idle, as the block does not
// enforce it. A length of 0 acts as 1, one above MAX_PATTERN as MAX_PATTERN.
module stream_pattern_occurrence_counter #(
    parameter int MAX_PATTERN = spoc_pkg::MAX_PATTERN_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [spoc_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [spoc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    spoc_text_if.sink                           i_text,
    spoc_result_if.source                       o_result
);

    localparam int DEPTH = MAX_PATTERN - 1;
    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int BW    = spoc_pkg::BYTE_W;
    localparam int LW    = spoc_pkg::LEN_W;

    // Configuration registers.
    logic [spoc_pkg::PATTERN_W-1:0] r_pattern_bytes;
    logic [LW-1:0]                  r_pattern_length;
    logic                           r_ignore_case;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_bytes  <= '0;
            r_pattern_length <= LW'(1);
            r_ignore_case    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (spoc_pkg::t_cfg_index'(i_cfg_index))
                spoc_pkg::CFG_PATTERN_BYTES:  r_pattern_bytes  <= i_cfg_data;
                spoc_pkg::CFG_PATTERN_LENGTH: r_pattern_length <= i_cfg_data[LW-1:0];
                spoc_pkg::CFG_IGNORE_CASE:    r_ignore_case    <= i_cfg_data[0];
                default: ;  // unused index: drop the write
            endcase
        end
    end

    // Clamp the length into 1..MAX_PATTERN.
    logic [LW-1:0] eff_len;

    always_comb begin
        if (r_pattern_length == '0) begin
            eff_len = LW'(1);
        end else if (r_pattern_length > LW'(MAX_PATTERN)) begin
            eff_len = LW'(MAX_PATTERN);
        end else begin
            eff_len = r_pattern_length;
        end
    end

    // Align the pattern to the taps: tap 0 is the current byte and must meet
    // the last pattern byte, tap j meets pattern byte len-1-j.
    logic [BW-1:0]    pat_arr  [MAX_PATTERN];
    logic [BW-1:0]    tap_pat  [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] tap_en;
    logic [LW-1:0]    idx_full [MAX_PATTERN];
    logic [IDX_W-1:0] idx      [MAX_PATTERN];

    always_comb begin
        for (int b = 0; b < MAX_PATTERN; b++) begin
            pat_arr[b] = r_pattern_bytes[BW*b +: BW];
        end
        for (int j = 0; j < MAX_PATTERN; j++) begin
            tap_en[j]   = LW'(j) < eff_len;
            idx_full[j] = eff_len - LW'(1) - LW'(j);
            idx[j]      = idx_full[j][IDX_W-1:0];
            tap_pat[j]  = tap_en[j] ? pat_arr[idx[j]] : '0;
        end
    end

    // Handshake and shared cell control.
    logic                   in_ready;
    logic                   take;
    spoc_pkg::t_cell_ctrl   cell_ctrl;

    assign take                  = i_text.valid && in_ready;
    assign cell_ctrl.shift       = take;
    assign cell_ctrl.clear       = i_text.data.stream_start;
    assign cell_ctrl.ignore_case = r_ignore_case;
    assign i_text.ready          = in_ready;

    // Window cell row: cell k holds the byte k+1 back and feeds cell k+1.
    logic [BW-1:0]    cell_byte  [DEPTH];
    logic [DEPTH-1:0] cell_valid;
    logic [DEPTH-1:0] cell_ok;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [BW-1:0] in_byte;
        logic          in_valid;

        if (k == 0) begin : g_head
            assign in_byte  = i_text.data.text_byte;
            assign in_valid = 1'b1;
        end else begin : g_link
            // A stream start empties the window behind the new byte.
            assign in_byte  = cell_byte[k-1];
            assign in_valid = cell_valid[k-1] && !i_text.data.stream_start;
        end

        spoc_cell u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctrl         (cell_ctrl),
            .i_byte         (in_byte),
            .i_valid        (in_valid),
            .i_pattern_byte (tap_pat[k+1]),
            .i_tap_en       (tap_en[k+1]),
            .o_byte         (cell_byte[k]),
            .o_valid        (cell_valid[k]),
            .o_tap_ok       (cell_ok[k])
        );
    end

    // Tap 0 is always in use since the length is at least 1.
    logic                   hit;
    spoc_pkg::t_count_ctrl  count_ctrl;

    assign hit = spoc_pkg::byte_match(i_text.data.text_byte, tap_pat[0], r_ignore_case)
               && (&cell_ok);

    assign count_ctrl.take    = take;
    assign count_ctrl.restart = i_text.data.stream_start;
    assign count_ctrl.hit     = hit;

    spoc_count u_count (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (count_ctrl),
        .i_out_ready (o_result.ready),
        .o_in_ready  (in_ready),
        .o_out_valid (o_result.valid),
        .o_hit       (o_result.data.match_hit),
        .o_count     (o_result.data.match_count)
    );

endmodule

/* rtl/core/spoc_checker.sv */
// Port-level checks of the pattern occurrence counter, bound to the top level.
module spoc_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             i_in_ready,
    input logic                             i_in_start,
    input logic                             i_out_valid,
    input logic                             i_out_ready,
    input logic                             i_out_hit,
    input logic [spoc_pkg::COUNT_W-1:0]     i_out_count
);

    // Every input transfer shows its result in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> i_out_valid)
        else $error("no result after an input transfer");

    // The input may only stall while a result waits to be taken.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output register");

    // A stream start restarts the count at the hit of that byte.
    a_restart_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_start)
        |=> i_out_count == {{(spoc_pkg::COUNT_W-1){1'b0}}, i_out_hit})
        else $error("count not restarted by stream start");

    // A stalled result holds.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready)
        |=> (i_out_valid && $stable(i_out_hit) && $stable(i_out_count)))
        else $error("stalled result changed");

endmodule

bind stream_pattern_occurrence_counter spoc_checker u_spoc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_text.valid),
    .i_in_ready  (i_text.ready),
    .i_in_start  (i_text.data.stream_start),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_hit   (o_result.data.match_hit),
    .i_out_count (o_result.data.match_count)
);

/* dv/stream_pattern_occurrence_counter_tb.sv */
// Self-checking testbench for the streaming pattern occurrence counter.
`timescale 1ns / 100ps

module stream_pattern_occurrence_counter_tb;
    import spoc_pkg::*;

    localparam int WINDOW    = MAX_PATTERN_DEF - 1;
    localparam int N_PHASES  = 9;
    localparam int PHASE_LEN = 100;

    // Index 3 has no register behind it; a write there must change nothing.
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    spoc_text_if   text_ch ();
    spoc_result_if result_ch ();

    stream_pattern_occurrence_counter DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_text      (text_ch),
        .o_result    (result_ch)
    );

    // Tracks the configured pattern and the text window, works out the hit
    // flag and running count for every transferred byte, and checks results.
    class occurrence_tracker;
        logic [PATTERN_W-1:0] pattern;
        logic [LEN_W-1:0]     length_reg;
        logic                 fold_case;
        logic [BYTE_W-1:0]    history[WINDOW];
        int unsigned          held;
        logic [COUNT_W-1:0]   total;
        t_result_item         expected_counts[$];
        int unsigned          failures;

        function void clear_reset();
            pattern    = '0;
            length_reg = 4'd1;
            fold_case  = 1'b0;
            foreach (history[k]) history[k] = '0;
            held      = 0;
            total     = '0;
            failures  = 0;
            expected_counts.delete();
        endfunction

        function void write_config(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_PATTERN_BYTES:  pattern = val[PATTERN_W-1:0];
                CFG_PATTERN_LENGTH: length_reg = val[LEN_W-1:0];
                CFG_IGNORE_CASE:    fold_case = val[0];
                default: ;
            endcase
        endfunction

        function logic [BYTE_W-1:0] lower(logic [BYTE_W-1:0] b);
            if (fold_case && b >= "A" && b <= "Z") return b + 8'd32;
            return b;
        endfunction

        function int unsigned span();
            if (length_reg == 0) return 1;
            if (length_reg > MAX_PATTERN_DEF) return MAX_PATTERN_DEF;
            return length_reg;
        endfunction

        function void take_text(t_text_item it);
            int unsigned       n;
            int unsigned       back;
            logic              hit;
            logic [BYTE_W-1:0] txt;
            t_result_item      res;
            if (it.stream_start) begin
                foreach (history[k]) history[k] = '0;
                held  = 0;
                total = '0;
            end
            n   = span();
            hit = (held + 1 >= n);
            // Pattern byte k must sit n-1-k bytes behind the current byte.
            for (int k = 0; k < n && hit; k++) begin
                back = n - 1 - k;
                txt  = (back == 0) ? it.text_byte : history[back-1];
                if (lower(txt) != lower(pattern[8*k +: 8])) hit = 1'b0;
            end
            if (hit && total != '1) total++;
            for (int k = WINDOW - 1; k > 0; k--) history[k] = history[k-1];
            history[0] = it.text_byte;
            if (held < WINDOW) held++;
            res.match_hit   = hit;
            res.match_count = total;
            expected_counts.push_back(res);
        endfunction

        function void check_result(t_result_item got);
            t_result_item want;
            if (expected_counts.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: result with nothing expected: hit=%0b count=%0d",
                             $realtime, got.match_hit, got.match_count);
                return;
            end
            want = expected_counts.pop_front();
            if (got.match_hit !== want.match_hit) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: match_hit expected %0b, got %0b", $realtime,
                             want.match_hit, got.match_hit);
            end
            if (got.match_count !== want.match_count) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: match_count expected %0d, got %0d", $realtime,
                             want.match_count, got.match_count);
            end
        endfunction

        function int unsigned pending();
            return expected_counts.size();
        endfunction
    endclass

    occurrence_tracker tracker;

    // Sender burst state; gaps_on off gives back-to-back transfers.
    int unsigned burst_left;
    bit          gaps_on;

    // Receiver stall pattern, reshuffled each time the step counter wraps.
    logic [15:0] rx_mask = '1;
    logic [5:0]  rx_step = '0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Hold ready to a rotating mask; bit 0 stays set so the receiver is ready at
    // least once in every turn of the mask. Some windows have no stalls.
    always @(posedge clk) begin
        if (rx_step == 0) begin
            if ($urandom_range(0, 3) == 0) rx_mask = '1;
            else rx_mask = 16'($urandom) | 16'h0001;
        end
        result_ch.ready <= rx_mask[rx_step[3:0]];
        rx_step         <= rx_step + 6'd1;
    end

    // Sample both channels before this edge's updates land. Note the input
    // first so a same-cycle result would still find its expectation.
    always @(posedge clk) begin
        if (rst_n) begin
            if (text_ch.valid && text_ch.ready) tracker.take_text(text_ch.data);
            if (result_ch.valid && result_ch.ready) tracker.check_result(result_ch.data);
        end
    end

    // Hold one byte on the channel until it transfers.
    task automatic send_text(logic [BYTE_W-1:0] b, logic start);
        text_ch.valid             <= 1'b1;
        text_ch.data.text_byte    <= b;
        text_ch.data.stream_start <= start;
        do @(posedge clk); while (!text_ch.ready);
    endtask

    // Send one byte; with gaps_on, a random gap opens when the burst runs out.
    task automatic push_byte(logic [BYTE_W-1:0] b, logic start);
        if (gaps_on && burst_left == 0) begin
            text_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left > 0) burst_left--;
        send_text(b, start);
    endtask

    task automatic push_string(string s, logic start_first);
        for (int k = 0; k < s.len(); k++) push_byte(s[k], start_first && k == 0);
    endtask

    // Drop valid and let every outstanding result drain before a write.
    // Wait for the next edge first so the monitor has noted the last transfer.
    task automatic drain();
        text_ch.valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        tracker.write_config(idx, val);
    endtask

    task automatic set_pattern(logic [PATTERN_W-1:0] pat, logic [LEN_W-1:0] len,
                               logic nocase);
        drain();
        cfg_write(CFG_PATTERN_BYTES, pat);
        cfg_write(CFG_PATTERN_LENGTH, CFG_DATA_W'(len));
        cfg_write(CFG_IGNORE_CASE, CFG_DATA_W'(nocase));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [PATTERN_W-1:0] pack_pattern(string s);
        logic [PATTERN_W-1:0] p;
        p = '0;
        for (int k = 0; k < s.len() && k < 8; k++) p[8*k +: 8] = s[k];
        return p;
    endfunction

    function automatic logic [BYTE_W-1:0] swap_case(logic [BYTE_W-1:0] b);
        if ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z")) return b ^ 8'h20;
        return b;
    endfunction

    // Pattern bytes come mostly from a tiny alphabet so partial matches,
    // overlaps and case variants are frequent.
    function automatic logic [BYTE_W-1:0] alphabet_byte();
        case ($urandom_range(0, 4))
            0: return "a";
            1: return "A";
            2: return "b";
            3: return "B";
            default: return 8'h00;
        endcase
    endfunction

    // Noise byte: mostly a pattern byte, sometimes case-swapped, else
    // alphabet or anything at all.
    function automatic logic [BYTE_W-1:0] noise_byte(logic [PATTERN_W-1:0] pat,
                                                     int unsigned n);
        int unsigned       pick;
        logic [BYTE_W-1:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
            b = pat[8*$urandom_range(0, n - 1) +: 8];
            if ($urandom_range(0, 9) < 3) b = swap_case(b);
        end else if (pick < 85) begin
            b = alphabet_byte();
        end else begin
            b = 8'($urandom_range(0, 255));
        end
        return b;
    endfunction

    initial begin
        logic [PATTERN_W-1:0] pat;
        logic [LEN_W-1:0]     len;
        logic                 nocase;
        int unsigned          n;
        int unsigned          sent;
        logic [BYTE_W-1:0]    b;

        tracker   = new();
        tracker.clear_reset();
        rst_n     = 1'b0;
        clk       = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        text_ch.valid  = 1'b0;
        text_ch.data   = '0;
        burst_left = 0;
        gaps_on    = 1'b1;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: one-byte pattern of value zero, so zero bytes hit.
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);

        // Overlapping two-byte pattern; the first byte of a stream can't hit,
        // and case matters.
        set_pattern(pack_pattern("aa"), 4'd2, 1'b0);
        push_string("aaaA", 1'b1);

        // Length zero acts as one; stream_start mid-run clears the count.
        set_pattern(pack_pattern("ab"), 4'd0, 1'b0);
        push_byte("a", 1'b0);
        push_byte("b", 1'b0);
        push_byte("a", 1'b1);

        // Length above the maximum acts as eight; folded compare on both sides.
        set_pattern(pack_pattern("ABCDEFGH"), 4'd15, 1'b1);
        push_string("abcDEfgh", 1'b1);

        // Folding covers A-Z only: the neighbors of that range stay distinct.
        // The write to the unused index must leave the pattern alone.
        set_pattern(pack_pattern("@["), 4'd2, 1'b1);
        cfg_write(CFG_UNUSED, '1);
        cfg_we <= 1'b0;
        @(posedge clk);
        push_string("`{@[", 1'b1);

        // Random phases: new settings each time, extremes of length first,
        // and a fully random pattern once so every pattern bit toggles.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            for (int k = 0; k < 8; k++)
                pat[8*k +: 8] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                            : alphabet_byte();
            if (ph == 2) pat = {$urandom, $urandom};
            if (ph == 5) pat = ~pat;
            case (ph)
                0:       len = 4'd1;
                1:       len = 4'd8;
                3:       len = 4'($urandom_range(9, 15));
                default: len = 4'($urandom_range(0, 8));
            endcase
            nocase  = 1'($urandom_range(0, 1));
            gaps_on = (ph % 3 != 1);
            set_pattern(pat, len, nocase);
            n    = tracker.span();
            sent = 0;
            while (sent < PHASE_LEN) begin
                if ($urandom_range(0, 3) == 0) begin
                    // Plant a whole occurrence, occasionally with case swapped.
                    for (int k = 0; k < n; k++) begin
                        b = pat[8*k +: 8];
                        if ($urandom_range(0, 9) < 3) b = swap_case(b);
                        push_byte(b, 1'b0);
                    end
                    sent += n;
                end else begin
                    push_byte(noise_byte(pat, n), 1'($urandom_range(0, 39) == 0));
                    sent++;
                end
            end
        end

        // Let the last results drain, then wait on for stray output.
        text_ch.valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        if (tracker.failures == 0 && tracker.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Stop a hung run: the limit lies far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
